[rtl/rcba_pkg.sv]
// Shared types, codes and defaults for the reference-counted bucket allocator.
`default_nettype none

package rcba_pkg;

    // Field widths fixed by the transaction format
    localparam int FLAG_KEY_W = 32;
    localparam int BUCKET_W   = 4;
    localparam int STATUS_W   = 3;
    localparam int USED_W     = 5;

    // Default sizing of the slot table
    localparam int NUM_BUCKETS_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int KEY_WIDTH_DEF   = 32;

    typedef enum logic {
        FUNC_ACQUIRE = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_e;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_UNKNOWN   = 3'd1,
        STATUS_UNDERFLOW = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_SATURATED = 3'd4
    } status_e;

    // Commands broadcast from the controller to the slot cells
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_INC   = 3'd1,
        OP_ALLOC = 3'd2,
        OP_DEC   = 3'd3,
        OP_FREE  = 3'd4,
        OP_ERASE = 3'd5
    } cmd_op_e;

    typedef struct packed {
        func_e                 func;
        logic [FLAG_KEY_W-1:0] flag_key;
    } in_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        status_e             status;
        logic                slot_freed;
        logic [USED_W-1:0]   buckets_used;
    } out_t;

endpackage

`default_nettype wire

[rtl/refcounted_bucket_allocator_unit.sv]
// Top level of the reference-counted bucket allocator: controller and row of slot cells.
//
// Each transaction maps a flag key to one of NUM_BUCKETS slots. The slots live in a row
// of cells; the lookup is a token passed from cell to cell, one cell per clock, along the
// whole chain. An acquire, a release that leaves the count above zero, or any error goes
// through the scan, execute and done states to the result on m_valid. A release that
// drops a count to zero then trims the high-water mark: it reads the top slot and lowers
// the mark past it while that slot is unused, until a mapped slot or an empty table. The
// controller works on one transaction at a time; a finished result sits in the output
// register, and the next transaction is accepted while it waits. No clearing pass is
// needed after reset.
`default_nettype none

module refcounted_bucket_allocator_unit #(
    parameter int NUM_BUCKETS = rcba_pkg::NUM_BUCKETS_DEF,
    parameter int COUNT_WIDTH = rcba_pkg::COUNT_WIDTH_DEF,
    parameter int KEY_WIDTH   = rcba_pkg::KEY_WIDTH_DEF
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  rcba_pkg::in_t  s_data,
    output logic           m_valid,
    input  wire            m_ready,
    output rcba_pkg::out_t m_data
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam int CNT_W = $clog2(NUM_BUCKETS + 1);
    localparam logic [CNT_W-1:0] NUM_SLOTS = CNT_W'(NUM_BUCKETS);
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(NUM_BUCKETS - 1);

    typedef struct packed {
        logic                   hit;
        logic [IDX_W-1:0]       idx;
        logic [COUNT_WIDTH-1:0] count;
        logic                   pop_hit;
        logic [IDX_W-1:0]       pop_idx;
    } tok_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic                 pop_en;
        logic [IDX_W-1:0]     pop_rank;
        rcba_pkg::cmd_op_e    op;
        logic [IDX_W-1:0]     idx;
        logic [IDX_W-1:0]     rank;
        logic                 push;
        logic [IDX_W-1:0]     top_idx;
    } bus_t;

    typedef struct packed {
        logic             mapped;
        logic             free;
        logic [IDX_W-1:0] rank;
    } view_t;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_EXEC    = 6'b000100,
        S_TRIM_RD = 6'b001000,
        S_TRIM_WR = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    rcba_pkg::func_e     func_reg, func_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]    hw_reg, hw_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [IDX_W-1:0]    res_bucket_reg, res_bucket_next;
    rcba_pkg::status_e   res_status_reg, res_status_next;
    logic                res_freed_reg, res_freed_next;
    view_t               top_reg, top_next;
    logic                m_valid_reg, m_valid_next;
    rcba_pkg::out_t      m_data_reg, m_data_next;

    bus_t  bus;
    tok_t  tok_in_arr  [NUM_BUCKETS];
    tok_t  tok_out_arr [NUM_BUCKETS];
    view_t view_arr    [NUM_BUCKETS];
    view_t view_any;
    tok_t  tok;

    // Row of slot cells, lookup token chained from cell 0 upward
    for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign tok_in_arr[i] = '0;
        end else begin : g_link
            assign tok_in_arr[i] = tok_out_arr[i-1];
        end
        rcba_slot_cell #(
            .NUM_BUCKETS (NUM_BUCKETS),
            .KEY_WIDTH   (KEY_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH),
            .CELL_IDX    (i),
            .bus_t       (bus_t),
            .tok_t       (tok_t),
            .view_t      (view_t)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .bus     (bus),
            .tok_in  (tok_in_arr[i]),
            .tok_out (tok_out_arr[i]),
            .view    (view_arr[i])
        );
    end

    // Merge the read bus: only the addressed cell drives nonzero
    always_comb begin
        view_any = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            view_any = view_t'(view_any | view_arr[i]);
        end
    end

    assign tok = tok_out_arr[NUM_BUCKETS-1];

    // Controller
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        scan_cnt_next   = scan_cnt_reg;
        hw_next         = hw_reg;
        depth_next      = depth_reg;
        res_bucket_next = res_bucket_reg;
        res_status_next = res_status_reg;
        res_freed_next  = res_freed_reg;
        top_next        = top_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        bus          = '0;
        bus.key      = key_reg;
        bus.pop_en   = (depth_reg != '0);
        bus.pop_rank = IDX_W'(depth_reg - CNT_W'(1));
        bus.op       = rcba_pkg::OP_NONE;
        bus.top_idx  = IDX_W'(hw_reg - CNT_W'(1));

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next     = s_data.func;
                    key_next      = KEY_WIDTH'(s_data.flag_key);
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                if (scan_cnt_reg == SCAN_LAST) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_bucket_next = '0;
                res_status_next = rcba_pkg::STATUS_OK;
                res_freed_next  = 1'b0;
                state_next      = S_DONE;
                if (func_reg == rcba_pkg::FUNC_ACQUIRE) begin
                    if (tok.hit) begin
                        if (&tok.count) begin
                            res_status_next = rcba_pkg::STATUS_SATURATED;
                        end else begin
                            bus.op          = rcba_pkg::OP_INC;
                            bus.idx         = tok.idx;
                            res_bucket_next = tok.idx;
                        end
                    end else if ((depth_reg != '0) && tok.pop_hit) begin
                        // Reuse the most recently freed slot
                        bus.op          = rcba_pkg::OP_ALLOC;
                        bus.idx         = tok.pop_idx;
                        depth_next      = depth_reg - CNT_W'(1);
                        res_bucket_next = tok.pop_idx;
                    end else if (hw_reg < NUM_SLOTS) begin
                        // Take the slot at the high-water mark
                        bus.op          = rcba_pkg::OP_ALLOC;
                        bus.idx         = IDX_W'(hw_reg);
                        hw_next         = hw_reg + CNT_W'(1);
                        res_bucket_next = IDX_W'(hw_reg);
                    end else begin
                        res_status_next = rcba_pkg::STATUS_FULL;
                    end
                end else begin
                    if (!tok.hit) begin
                        res_status_next = rcba_pkg::STATUS_UNKNOWN;
                    end else if (tok.count == '0) begin
                        res_status_next = rcba_pkg::STATUS_UNDERFLOW;
                    end else begin
                        res_bucket_next = tok.idx;
                        bus.idx         = tok.idx;
                        if (tok.count == COUNT_WIDTH'(1)) begin
                            // Last reference: unmap, push on the free list, then trim
                            bus.op         = rcba_pkg::OP_FREE;
                            bus.push       = (depth_reg < NUM_SLOTS);
                            bus.rank       = IDX_W'(depth_reg);
                            res_freed_next = 1'b1;
                            if (depth_reg < NUM_SLOTS) begin
                                depth_next = depth_reg + CNT_W'(1);
                            end
                            state_next = S_TRIM_RD;
                        end else begin
                            bus.op = rcba_pkg::OP_DEC;
                        end
                    end
                end
            end
            S_TRIM_RD: begin
                if (hw_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    top_next   = view_any;
                    state_next = S_TRIM_WR;
                end
            end
            S_TRIM_WR: begin
                if (top_reg.mapped) begin
                    state_next = S_DONE;
                end else begin
                    // Lower the mark past the unused top slot, erase it from the free list
                    hw_next = hw_reg - CNT_W'(1);
                    if (top_reg.free) begin
                        bus.op     = rcba_pkg::OP_ERASE;
                        bus.idx    = IDX_W'(hw_reg - CNT_W'(1));
                        bus.rank   = top_reg.rank;
                        depth_next = depth_reg - CNT_W'(1);
                    end
                    state_next = S_TRIM_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.bucket       = rcba_pkg::BUCKET_W'(res_bucket_reg);
                    m_data_next.status       = res_status_reg;
                    m_data_next.slot_freed   = res_freed_reg;
                    m_data_next.buckets_used = rcba_pkg::USED_W'(hw_reg);
                    m_valid_next             = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hw_reg      <= '0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        scan_cnt_reg   <= scan_cnt_next;
        res_bucket_reg <= res_bucket_next;
        res_status_reg <= res_status_next;
        res_freed_reg  <= res_freed_next;
        top_reg        <= top_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/rcba_slot_cell.sv]
// One slot cell: key, reference count, free-list rank, and one stage of the lookup chain.
`default_nettype none

module rcba_slot_cell #(
    parameter int  NUM_BUCKETS = rcba_pkg::NUM_BUCKETS_DEF,
    parameter int  KEY_WIDTH   = rcba_pkg::KEY_WIDTH_DEF,
    parameter int  COUNT_WIDTH = rcba_pkg::COUNT_WIDTH_DEF,
    parameter int  CELL_IDX    = 0,
    parameter type bus_t       = logic,
    parameter type tok_t       = logic,
    parameter type view_t      = logic
) (
    input  wire  aclk,
    input  wire  aresetn,
    input  bus_t bus,
    input  tok_t tok_in,
    output tok_t tok_out,
    output view_t view
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                   mapped_reg, mapped_next;
    logic                   free_reg, free_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]       rank_reg, rank_next;
    tok_t                   tok_reg, tok_next;
    logic                   mine;

    // Apply the broadcast command to this slot
    always_comb begin
        mapped_next = mapped_reg;
        free_next   = free_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        rank_next   = rank_reg;
        mine        = (bus.idx == MY_IDX);
        unique case (bus.op)
            rcba_pkg::OP_INC: begin
                if (mine) begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
            end
            rcba_pkg::OP_ALLOC: begin
                if (mine) begin
                    mapped_next = 1'b1;
                    free_next   = 1'b0;
                    key_next    = bus.key;
                    count_next  = COUNT_WIDTH'(1);
                end
            end
            rcba_pkg::OP_DEC: begin
                if (mine) begin
                    count_next = count_reg - COUNT_WIDTH'(1);
                end
            end
            rcba_pkg::OP_FREE: begin
                if (mine) begin
                    mapped_next = 1'b0;
                    count_next  = '0;
                    free_next   = bus.push;
                    rank_next   = bus.rank;
                end
            end
            rcba_pkg::OP_ERASE: begin
                if (mine) begin
                    free_next = 1'b0;
                end else if (free_reg && (rank_reg > bus.rank)) begin
                    rank_next = rank_reg - IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Lookup stage: keep the first hit from below, flag the top of the free list
    always_comb begin
        tok_next = tok_in;
        if (!tok_in.hit && mapped_reg && (key_reg == bus.key)) begin
            tok_next.hit   = 1'b1;
            tok_next.idx   = MY_IDX;
            tok_next.count = count_reg;
        end
        if (bus.pop_en && free_reg && (rank_reg == bus.pop_rank)) begin
            tok_next.pop_hit = 1'b1;
            tok_next.pop_idx = MY_IDX;
        end
    end

    // Drive this slot onto the read bus when it is the top slot
    always_comb begin
        view = '0;
        if (bus.top_idx == MY_IDX) begin
            view.mapped = mapped_reg;
            view.free   = free_reg;
            view.rank   = rank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapped_reg <= 1'b0;
            free_reg   <= 1'b0;
            count_reg  <= '0;
        end else begin
            mapped_reg <= mapped_next;
            free_reg   <= free_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        rank_reg <= rank_next;
        tok_reg  <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[verif/refcounted_bucket_allocator_unit_tb.sv]
// Self-checking testbench for the reference-counted bucket allocator unit.
`default_nettype none

module refcounted_bucket_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = rcba_pkg::NUM_BUCKETS_DEF;
    localparam int CW = rcba_pkg::COUNT_WIDTH_DEF;
    localparam int KW = rcba_pkg::FLAG_KEY_W;
    localparam int BW = rcba_pkg::BUCKET_W;
    localparam int UW = rcba_pkg::USED_W;
    localparam logic [CW-1:0] COUNT_TOP = '1;
    localparam int IDLE_PCT = 38;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    rcba_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    rcba_pkg::out_t m_data;

    // Set to suppress idling on both sides
    bit steady = 1'b0;

    // Shadow copy of the slot table
    logic [KW-1:0] key_of    [NB] = '{default: '0};
    logic [CW-1:0] refs_of   [NB] = '{default: '0};
    bit            held      [NB] = '{default: 1'b0};
    logic [BW-1:0] free_lifo [NB] = '{default: '0};
    int            free_cnt = 0;
    int            top_mark = 0;

    // Predicted results still in flight
    rcba_pkg::out_t outcome_q [$];
    rcba_pkg::out_t want;
    int unsigned mismatches = 0;

    refcounted_bucket_allocator_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    function automatic int lookup_key(logic [KW-1:0] key);
        for (int i = 0; i < NB; i++) begin
            if (held[i] && key_of[i] == key) return i;
        end
        return -1;
    endfunction

    // Pick some mapped key, starting at a random slot
    function automatic bit pick_held_key(output logic [KW-1:0] key);
        int start;
        start = int'($urandom_range(NB - 1));
        key = '0;
        for (int i = 0; i < NB; i++) begin
            if (held[(start + i) % NB]) begin
                key = key_of[(start + i) % NB];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the shadow table by one request and return the result it gives
    function automatic rcba_pkg::out_t predict_slot_outcome(rcba_pkg::in_t req);
        rcba_pkg::out_t res;
        int   s;
        int   slot;
        int   w;
        res = '0;
        res.status = rcba_pkg::STATUS_OK;
        s = lookup_key(req.flag_key);
        if (req.func == rcba_pkg::FUNC_ACQUIRE) begin
            if (s >= 0) begin
                if (refs_of[s] == COUNT_TOP) begin
                    res.status = rcba_pkg::STATUS_SATURATED;
                end else begin
                    refs_of[s]++;
                    res.bucket = BW'(s);
                end
            end else begin
                // Reuse the most recently freed slot, else grow the mark
                slot = -1;
                if (free_cnt > 0) begin
                    free_cnt--;
                    slot = int'(free_lifo[free_cnt]);
                end else if (top_mark < NB) begin
                    slot = top_mark;
                    top_mark++;
                end
                if (slot < 0) begin
                    res.status = rcba_pkg::STATUS_FULL;
                end else begin
                    key_of[slot]  = req.flag_key;
                    refs_of[slot] = CW'(1);
                    held[slot]    = 1'b1;
                    res.bucket    = BW'(slot);
                end
            end
        end else if (s < 0) begin
            res.status = rcba_pkg::STATUS_UNKNOWN;
        end else if (refs_of[s] == '0) begin
            res.status = rcba_pkg::STATUS_UNDERFLOW;
        end else begin
            res.bucket = BW'(s);
            refs_of[s]--;
            if (refs_of[s] == '0) begin
                res.slot_freed = 1'b1;
                held[s]   = 1'b0;
                key_of[s] = '0;
                if (free_cnt < NB) begin
                    free_lifo[free_cnt] = BW'(s);
                    free_cnt++;
                end
                // Trim unused slots off the top and erase them from the free list
                while (top_mark > 0 && refs_of[top_mark-1] == '0 && !held[top_mark-1]) begin
                    top_mark--;
                    w = 0;
                    for (int r = 0; r < free_cnt; r++) begin
                        if (int'(free_lifo[r]) != top_mark) begin
                            free_lifo[w] = free_lifo[r];
                            w++;
                        end
                    end
                    free_cnt = w;
                end
            end
        end
        res.buckets_used = UW'(top_mark);
        return res;
    endfunction

    // Present one request and hold it until accepted; returns at a falling edge
    task automatic send_item(input rcba_pkg::func_e f, input logic [KW-1:0] key);
        rcba_pkg::in_t req;
        req.func     = f;
        req.flag_key = key;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        outcome_q.insert(outcome_q.size(), predict_slot_outcome(req));
        @(negedge aclk);
    endtask

    // Hold the sender until every predicted result has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(negedge aclk);
    endtask

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none pending: bucket=%0d status=%0d freed=%0b used=%0d",
                             $realtime, m_data.bucket, m_data.status, m_data.slot_freed,
                             m_data.buckets_used);
            end else begin
                want = outcome_q.pop_front();
                if (m_data.bucket !== want.bucket || m_data.status !== want.status ||
                    m_data.slot_freed !== want.slot_freed ||
                    m_data.buckets_used !== want.buckets_used) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("%0t: mismatch: expected bucket=%0d status=%0d freed=%0b used=%0d",
                               $realtime, want.bucket, want.status, want.slot_freed,
                               want.buckets_used);
                        $display(", got bucket=%0d status=%0d freed=%0b used=%0d",
                                 m_data.bucket, m_data.status, m_data.slot_freed,
                                 m_data.buckets_used);
                    end
                end
            end
        end
    end

    // Key extremes, repeat acquire, free on last release, unknown key on release
    task automatic test_key_extremes();
        send_item(rcba_pkg::FUNC_ACQUIRE, 32'h0000_0000);
        send_item(rcba_pkg::FUNC_ACQUIRE, 32'hFFFF_FFFF);
        send_item(rcba_pkg::FUNC_ACQUIRE, 32'h0000_0000);
        send_item(rcba_pkg::FUNC_RELEASE, 32'hFFFF_FFFF);
        send_item(rcba_pkg::FUNC_RELEASE, 32'h0000_0000);
        send_item(rcba_pkg::FUNC_RELEASE, 32'h0000_0000);
        send_item(rcba_pkg::FUNC_RELEASE, 32'h0000_0000);
    endtask

    // Fill every slot, overflow, then reuse freed slots in LIFO order
    task automatic test_table_full_and_reuse();
        for (int i = 0; i < NB; i++) send_item(rcba_pkg::FUNC_ACQUIRE, 32'h1000_0000 + i);
        send_item(rcba_pkg::FUNC_ACQUIRE, 32'hDEAD_BEEF);
        send_item(rcba_pkg::FUNC_RELEASE, 32'h1000_0005);
        send_item(rcba_pkg::FUNC_RELEASE, 32'h1000_0009);
        send_item(rcba_pkg::FUNC_ACQUIRE, 32'h5555_AAAA);
        send_item(rcba_pkg::FUNC_ACQUIRE, 32'hAAAA_5555);
    endtask

    // Mostly well-formed traffic over a small key pool, in fill and drain rounds
    task automatic test_random_traffic();
        logic [KW-1:0] pool [24];
        logic [KW-1:0] key;
        int acq_pct;
        for (int i = 0; i < 24; i++) pool[i] = $urandom();
        for (int round = 0; round < 10; round++) begin
            acq_pct = (round % 2 == 1) ? 35 : 70;
            steady  = (round == 3);
            if (round == 6) wait_for_results();
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(99) < acq_pct) begin
                    key = ($urandom_range(99) < 85) ? pool[$urandom_range(23)] : $urandom();
                    send_item(rcba_pkg::FUNC_ACQUIRE, key);
                end else if ($urandom_range(99) < 85 && pick_held_key(key)) begin
                    send_item(rcba_pkg::FUNC_RELEASE, key);
                end else begin
                    key = ($urandom_range(99) < 50) ? pool[$urandom_range(23)] : $urandom();
                    send_item(rcba_pkg::FUNC_RELEASE, key);
                end
            end
        end
        steady = 1'b0;
    endtask

    // Stack up references on one key, then release it past zero
    task automatic test_deep_count();
        logic [KW-1:0] key;
        steady = 1'b1;
        if (!pick_held_key(key)) key = 32'h5A5A_A5A5;
        repeat (20) send_item(rcba_pkg::FUNC_ACQUIRE, key);
        repeat (22) send_item(rcba_pkg::FUNC_RELEASE, key);
        send_item(rcba_pkg::FUNC_ACQUIRE, key);
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_key_extremes();
        test_table_full_and_reuse();
        test_random_traffic();
        test_deep_count();

        // Drain, then watch for stray results
        wait_for_results();
        repeat (4 * NB + 16) @(negedge aclk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("PASS refcounted_bucket_allocator_unit");
        end else begin
            $display("FAIL refcounted_bucket_allocator_unit");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #80_000_000;
        $display("FAIL refcounted_bucket_allocator_unit");
        $finish;
    end

endmodule

`default_nettype wire
